FILE: rtl/pcs_pkg.sv
// Shared types and constants for the priority CPU/IO tick scheduler.
// Used by pcs_cell and priority_cpu_io_tick_scheduler; no dependencies.
package pcs_pkg;

  localparam int Slots    = 16;
  localparam int SlotW    = $clog2(Slots);
  localparam int CountW   = SlotW + 1;
  localparam int TimeW    = 12;
  localparam int LeftW    = TimeW + 2;
  localparam int PrioW    = 3;
  localparam int CycleW   = 16;

  typedef enum logic [2:0] {
    KIND_LOADED    = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_IDLE      = 3'd2,
    KIND_RAN       = 3'd3,
    KIND_COMPLETED = 3'd4
  } kind_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_t;

  typedef enum logic {
    REG_CPU_QUANTUM = 1'b0,
    REG_IO_QUANTUM  = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADMIT,
    S_IO,
    S_CPU,
    S_INS
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [PrioW-1:0] prio;
    logic [SlotW-1:0] slot;
  } entry_t;

  typedef struct packed {
    logic             ins;
    logic             pop;
    logic [PrioW-1:0] prio;
    logic [SlotW-1:0] slot;
  } cell_ctl_t;

endpackage

FILE: rtl/pcs_cell.sv
// One cell of the sorted ready queue: holds one entry, shifts on insert/pop.
// Depends on pcs_pkg.
module pcs_cell
  import pcs_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  cell_ctl_t ctl,
  input  entry_t    prev,
  input  logic      prev_keep,
  input  entry_t    next,
  output entry_t    cur,
  output logic      keep
);

  entry_t cur_next;

  assign keep = cur.valid && (cur.prio <= ctl.prio);

  always_comb begin
    cur_next = cur;
    if (ctl.pop) begin
      cur_next = next;
    end else if (ctl.ins) begin
      if (keep) begin
        cur_next = cur;
      end else if (prev_keep) begin
        cur_next = '{valid: 1'b1, prio: ctl.prio, slot: ctl.slot};
      end else begin
        cur_next = prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur.valid <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
    end
    cur.prio <= cur_next.prio;
    cur.slot <= cur_next.slot;
  end

  a_contig: assert property (@(posedge clk) disable iff (rst) cur.valid |-> prev.valid)
    else $error("ready queue has a gap");
  a_sorted: assert property (@(posedge clk) disable iff (rst)
    cur.valid |-> prev.prio <= cur.prio)
    else $error("ready queue out of order");
  a_oneop: assert property (@(posedge clk) disable iff (rst) !(ctl.ins && ctl.pop))
    else $error("insert and pop together");

endmodule

FILE: rtl/priority_cpu_io_tick_scheduler.sv
// Top level of the priority CPU/IO tick scheduler: process table, IO FIFO,
// sequencer and a chain of pcs_cell ready-queue cells. Depends on pcs_pkg.
//
//  channel | handshake            | fields
//  item in | start, busy          | op, proc_id, prio_level, arrival_cycle, io_time, cpu_time
//  result  | done                 | kind, out_id, exit_cycle
//  config  | cfg_valid, cfg_ready | cfg_index, cfg_data
//
// A load's result appears the next cycle.
// A tick steps through admission of the processes that have arrived, an IO
// step, a CPU step, and an insert step when the run process goes back to the
// ready queue. Its result is registered from the CPU step.
// The ready-queue insert through the cell chain sets one admission per cycle.
// Reset clears counters and queue valid bits; no clearing pass.
// Results are strobed on done for one cycle; the receiver cannot stall.
module priority_cpu_io_tick_scheduler
  import pcs_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic              op,
  input  logic [7:0]        proc_id,
  input  logic [PrioW-1:0]  prio_level,
  input  logic [CycleW-1:0] arrival_cycle,
  input  logic [TimeW-1:0]  io_time,
  input  logic [TimeW-1:0]  cpu_time,
  output logic              done,
  output logic [2:0]        kind,
  output logic [7:0]        out_id,
  output logic [CycleW-1:0] exit_cycle,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic              cfg_index,
  input  logic [7:0]        cfg_data
);

  state_t state, state_next;

  logic [7:0]              tbl_id   [Slots];
  logic [PrioW-1:0]        tbl_prio [Slots];
  logic [CycleW-1:0]       tbl_arr  [Slots];
  logic signed [LeftW-1:0] tbl_io   [Slots];
  logic signed [LeftW-1:0] tbl_cpu  [Slots];
  logic                    tbl_fin  [Slots];

  logic [SlotW-1:0]  io_fifo [Slots];
  logic [SlotW-1:0]  io_head;
  logic [CountW-1:0] io_count;
  logic [CountW-1:0] loaded_count;
  logic [CountW-1:0] admitted_count;
  logic [CycleW-1:0] tick_count;
  logic [7:0]        cpu_quantum;
  logic [7:0]        io_quantum;
  logic [PrioW-1:0]  pend_prio;
  logic [SlotW-1:0]  pend_slot;

  entry_t    cells [Slots];
  logic      keeps [Slots];
  cell_ctl_t ctl;

  logic                    accept;
  logic [SlotW-1:0]        rd_slot;
  logic signed [LeftW-1:0] rd_io, rd_cpu, io_sub, cpu_sub;
  logic                    can_admit, io_done, complete, cpu_requeue, cpu_to_io;
  logic [SlotW-1:0]        tail;

  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign tail      = io_head + io_count[SlotW-1:0];

  always_comb begin
    unique case (state)
      S_ADMIT: rd_slot = admitted_count[SlotW-1:0];
      S_IO:    rd_slot = io_fifo[io_head];
      default: rd_slot = cells[0].slot;
    endcase
  end

  assign rd_io   = tbl_io[rd_slot];
  assign rd_cpu  = tbl_cpu[rd_slot];
  assign io_sub  = rd_io - $signed({{(LeftW-8){1'b0}}, io_quantum});
  assign cpu_sub = rd_cpu - $signed({{(LeftW-8){1'b0}}, cpu_quantum});

  assign can_admit   = (admitted_count < loaded_count) && (tbl_arr[rd_slot] <= tick_count);
  assign io_done     = (io_sub <= 0);
  assign complete    = (rd_cpu == 1) && (rd_io <= 0) && tbl_fin[rd_slot];
  assign cpu_to_io   = !complete && (rd_io > 0);
  assign cpu_requeue = !complete && !cpu_to_io;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '{ins: 1'b0, pop: 1'b0, prio: tbl_prio[rd_slot], slot: rd_slot};
    unique case (state)
      S_IDLE: begin
        if (accept && op == OP_TICK) state_next = S_ADMIT;
      end
      S_ADMIT: begin
        if (can_admit) begin
          ctl.ins = 1'b1;
        end else begin
          state_next = S_IO;
        end
      end
      S_IO: begin
        ctl.ins    = (io_count != 0) && io_done;
        state_next = S_CPU;
      end
      S_CPU: begin
        ctl.pop    = cells[0].valid;
        state_next = (cells[0].valid && cpu_requeue) ? S_INS : S_IDLE;
      end
      S_INS: begin
        ctl.ins    = 1'b1;
        ctl.prio   = pend_prio;
        ctl.slot   = pend_slot;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  for (genvar i = 0; i < Slots; i++) begin : g_cell
    entry_t prev_e, next_e;
    logic   prev_k;
    if (i == 0) begin : g_first
      assign prev_e = '{valid: 1'b1, prio: '0, slot: '0};
      assign prev_k = 1'b1;
    end else begin : g_mid
      assign prev_e = cells[i-1];
      assign prev_k = keeps[i-1];
    end
    if (i == Slots - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_nxt
      assign next_e = cells[i+1];
    end
    pcs_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ctl       (ctl),
      .prev      (prev_e),
      .prev_keep (prev_k),
      .next      (next_e),
      .cur       (cells[i]),
      .keep      (keeps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_count   <= '0;
      admitted_count <= '0;
      io_head        <= '0;
      io_count       <= '0;
      tick_count     <= '0;
      cpu_quantum    <= 8'd3;
      io_quantum     <= 8'd6;
      done           <= 1'b0;
    end else begin
      done <= (state == S_CPU) || (state == S_IDLE && accept && op == OP_LOAD);
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_CPU_QUANTUM) cpu_quantum <= cfg_data;
        else                              io_quantum  <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (accept && op == OP_LOAD) begin
            out_id     <= '0;
            exit_cycle <= '0;
            if (loaded_count == CountW'(Slots)) begin
              kind <= KIND_FULL;
            end else begin
              kind                                 <= KIND_LOADED;
              tbl_id[loaded_count[SlotW-1:0]]   <= proc_id;
              tbl_prio[loaded_count[SlotW-1:0]] <= prio_level;
              tbl_arr[loaded_count[SlotW-1:0]]  <= arrival_cycle;
              tbl_io[loaded_count[SlotW-1:0]]   <= $signed({2'b00, io_time});
              tbl_cpu[loaded_count[SlotW-1:0]]  <= $signed({2'b00, cpu_time});
              tbl_fin[loaded_count[SlotW-1:0]]  <= (cpu_time == '0);
              loaded_count                         <= loaded_count + 1'b1;
            end
          end
        end
        S_ADMIT: begin
          if (can_admit) admitted_count <= admitted_count + 1'b1;
        end
        S_IO: begin
          if (io_count != 0) begin
            io_head         <= io_head + 1'b1;
            tbl_io[rd_slot] <= io_sub;
            if (io_done) begin
              io_count <= io_count - 1'b1;
              if (rd_cpu <= 0) tbl_cpu[rd_slot] <= LeftW'(1);
            end else begin
              io_fifo[tail] <= rd_slot;
            end
          end
        end
        S_CPU: begin
          out_id     <= cells[0].valid ? tbl_id[rd_slot] : 8'd0;
          exit_cycle <= (cells[0].valid && complete) ?
                        ((tick_count == '1) ? tick_count : tick_count + 1'b1) : '0;
          if (tick_count != '1) tick_count <= tick_count + 1'b1;
          if (!cells[0].valid) begin
            kind <= KIND_IDLE;
          end else if (complete) begin
            kind <= KIND_COMPLETED;
          end else begin
            kind      <= KIND_RAN;
            pend_prio <= tbl_prio[rd_slot];
            pend_slot <= rd_slot;
            if (cpu_sub <= 0 && rd_io <= 0) begin
              tbl_cpu[rd_slot] <= LeftW'(1);
              tbl_fin[rd_slot] <= 1'b1;
            end else begin
              tbl_cpu[rd_slot] <= cpu_sub;
            end
            if (cpu_to_io) begin
              io_fifo[tail] <= rd_slot;
              io_count      <= io_count + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    accept && op == OP_TICK |=> busy)
    else $error("tick did not start");
  a_io_bound: assert property (@(posedge clk) disable iff (rst)
    io_count <= CountW'(Slots))
    else $error("io fifo overflow");
  a_admit_bound: assert property (@(posedge clk) disable iff (rst)
    admitted_count <= loaded_count)
    else $error("admitted beyond loaded");

endmodule

FILE: tb/priority_cpu_io_tick_scheduler_tb.sv
// Testbench for priority_cpu_io_tick_scheduler: directed table, then random load/tick
// traffic checked against an in-bench scheduler predictor. Depends on pcs_pkg and the DUT.
`timescale 1ns / 1ps
module priority_cpu_io_tick_scheduler_tb;
  import pcs_pkg::*;

  typedef struct {
    kind_t             kind;
    logic [7:0]        id;
    logic [CycleW-1:0] exitc;
  } sched_res_t;

  typedef struct {
    op_t               op;
    logic [7:0]        id;
    logic [PrioW-1:0]  prio;
    logic [CycleW-1:0] arr;
    logic [TimeW-1:0]  io;
    logic [TimeW-1:0]  cpu;
    bit                typed;
    sched_res_t        res;
  } dir_row_t;

  localparam int WatchLimit = 5000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  logic              op = 1'b0;
  logic [7:0]        proc_id = '0;
  logic [PrioW-1:0]  prio_level = '0;
  logic [CycleW-1:0] arrival_cycle = '0;
  logic [TimeW-1:0]  io_time = '0;
  logic [TimeW-1:0]  cpu_time = '0;
  logic              done;
  logic [2:0]        kind;
  logic [7:0]        out_id;
  logic [CycleW-1:0] exit_cycle;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic              cfg_index = 1'b0;
  logic [7:0]        cfg_data = '0;

  priority_cpu_io_tick_scheduler dut (.*);

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // scheduler state mirror
  logic [7:0]        tbl_id   [Slots];
  logic [PrioW-1:0]  tbl_prio [Slots];
  logic [CycleW-1:0] tbl_arr  [Slots];
  int                tbl_io   [Slots];
  int                tbl_cpu  [Slots];
  bit                tbl_fin  [Slots];
  int                ready_q  [Slots];
  int                io_q     [Slots];
  int n_loaded = 0, n_admitted = 0, n_ready = 0, io_hd = 0, io_n = 0;
  int ticks = 0;
  int cpu_qnt = 3, io_qnt = 6;

  sched_res_t expected_q[$];
  dir_row_t   dir_rows[$];
  int         errs = 0;
  int         quiet = 0;

  function void ready_add(int s);
    int p;
    p = 0;
    if (n_ready >= Slots) return;
    while (p < n_ready && tbl_prio[ready_q[p]] <= tbl_prio[s]) p++;
    for (int k = n_ready; k > p; k--) ready_q[k] = ready_q[k-1];
    ready_q[p] = s;
    n_ready++;
  endfunction

  function void io_add(int s);
    if (io_n >= Slots) return;
    io_q[(io_hd + io_n) % Slots] = s;
    io_n++;
  endfunction

  function sched_res_t sched_predict(op_t o, logic [7:0] id, logic [PrioW-1:0] pr,
                                     logic [CycleW-1:0] arr, logic [TimeW-1:0] iot,
                                     logic [TimeW-1:0] cput);
    sched_res_t r;
    int s;
    r.kind = KIND_LOADED;
    r.id = '0;
    r.exitc = '0;
    if (o == OP_LOAD) begin
      if (n_loaded >= Slots) begin
        r.kind = KIND_FULL;
      end else begin
        tbl_id[n_loaded] = id;
        tbl_prio[n_loaded] = pr;
        tbl_arr[n_loaded] = arr;
        tbl_io[n_loaded] = iot;
        tbl_cpu[n_loaded] = cput;
        tbl_fin[n_loaded] = (cput == 0);
        n_loaded++;
      end
      return r;
    end
    while (n_admitted < n_loaded && int'(tbl_arr[n_admitted]) <= ticks) begin
      ready_add(n_admitted);
      n_admitted++;
    end
    if (io_n > 0) begin
      s = io_q[io_hd];
      io_hd = (io_hd + 1) % Slots;
      io_n--;
      tbl_io[s] -= io_qnt;
      if (tbl_io[s] <= 0) begin
        if (tbl_cpu[s] <= 0) tbl_cpu[s] = 1;
        ready_add(s);
      end else begin
        io_add(s);
      end
    end
    if (n_ready > 0) begin
      s = ready_q[0];
      for (int k = 1; k < n_ready; k++) ready_q[k-1] = ready_q[k];
      n_ready--;
      r.id = tbl_id[s];
      if (tbl_cpu[s] == 1 && tbl_io[s] <= 0 && tbl_fin[s]) begin
        r.kind = KIND_COMPLETED;
        r.exitc = (ticks + 1 > 65535) ? 16'hFFFF : 16'(ticks + 1);
      end else begin
        r.kind = KIND_RAN;
        tbl_cpu[s] -= cpu_qnt;
        if (tbl_cpu[s] <= 0 && tbl_io[s] <= 0) begin
          tbl_cpu[s] = 1;
          tbl_fin[s] = 1'b1;
          ready_add(s);
        end else if (tbl_io[s] > 0) begin
          io_add(s);
        end else begin
          ready_add(s);
        end
      end
    end else begin
      r.kind = KIND_IDLE;
    end
    if (ticks < 65535) ticks++;
    return r;
  endfunction

  task automatic send_item(int gap, op_t o, logic [7:0] id, logic [PrioW-1:0] pr,
                           logic [CycleW-1:0] arr, logic [TimeW-1:0] iot,
                           logic [TimeW-1:0] cput, bit typed, sched_res_t typed_res);
    sched_res_t r;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    op <= o;
    proc_id <= id;
    prio_level <= pr;
    arrival_cycle <= arr;
    io_time <= iot;
    cpu_time <= cput;
    do @(posedge clk); while (busy);
    r = sched_predict(o, id, pr, arr, iot, cput);
    expected_q.push_back(typed ? typed_res : r);
  endtask

  task automatic send_rand(int gap, op_t o);
    sched_res_t none;
    logic [TimeW-1:0] iot, cput;
    none = '{KIND_LOADED, 8'd0, 16'd0};
    iot = ($urandom_range(0, 9) == 0) ? TimeW'($urandom) : TimeW'($urandom_range(0, 40));
    cput = ($urandom_range(0, 9) == 0) ? TimeW'($urandom) : TimeW'($urandom_range(0, 20));
    send_item(gap, o, 8'($urandom), PrioW'($urandom),
              CycleW'(ticks + $urandom_range(0, 40)), iot, cput, 1'b0, none);
  endtask

  // drain, then wait out any in-flight tick before touching registers
  task automatic drain;
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic cfg_write(reg_idx_t idx, logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_CPU_QUANTUM) cpu_qnt = val;
    else io_qnt = val;
  endtask

  task automatic add_row(op_t o, logic [7:0] id, logic [PrioW-1:0] pr,
                         logic [CycleW-1:0] arr, logic [TimeW-1:0] iot,
                         logic [TimeW-1:0] cput, bit typed, kind_t k);
    dir_row_t d;
    d.op = o;
    d.id = id;
    d.prio = pr;
    d.arr = arr;
    d.io = iot;
    d.cpu = cput;
    d.typed = typed;
    d.res = '{k, 8'd0, 16'd0};
    dir_rows.push_back(d);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("unexpected result kind=%0d id=%0d exit=%0d",
                                 kind, out_id, exit_cycle);
      end else begin
        sched_res_t e;
        e = expected_q.pop_front();
        if (kind !== e.kind || out_id !== e.id || exit_cycle !== e.exitc) begin
          errs++;
          if (errs <= 10)
            $display("mismatch: exp kind=%0d id=%0d exit=%0d, got kind=%0d id=%0d exit=%0d",
                     e.kind, e.id, e.exitc, kind, out_id, exit_cycle);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= WatchLimit) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    sched_res_t none;
    none = '{KIND_LOADED, 8'd0, 16'd0};
    add_row(OP_TICK, 8'd0, 3'd0, 16'd0, 12'd0, 12'd0, 1'b1, KIND_IDLE);
    add_row(OP_LOAD, 8'd0, 3'd0, 16'd0, 12'd0, 12'd0, 1'b1, KIND_LOADED);
    add_row(OP_LOAD, 8'd255, 3'd7, 16'd0, 12'd4095, 12'd4095, 1'b1, KIND_LOADED);
    add_row(OP_LOAD, 8'h5A, 3'd3, 16'd2, 12'd10, 12'd5, 1'b1, KIND_LOADED);
    add_row(OP_LOAD, 8'hA5, 3'd3, 16'd1, 12'd0, 12'd7, 1'b1, KIND_LOADED);
    add_row(OP_LOAD, 8'h33, 3'd1, 16'd5, 12'd4, 12'd1, 1'b1, KIND_LOADED);
    for (int i = 0; i < 16; i++)
      add_row(OP_TICK, 8'd0, 3'd0, 16'd0, 12'd0, 12'd0, 1'b0, KIND_IDLE);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i])
      send_item($urandom_range(0, 4), dir_rows[i].op, dir_rows[i].id, dir_rows[i].prio,
                dir_rows[i].arr, dir_rows[i].io, dir_rows[i].cpu, dir_rows[i].typed,
                dir_rows[i].res);

    for (int ph = 0; ph < 3; ph++) begin
      drain();
      case (ph)
        0: begin
          cfg_write(REG_CPU_QUANTUM, 8'd1);
          cfg_write(REG_IO_QUANTUM, 8'd1);
        end
        1: begin
          cfg_write(REG_CPU_QUANTUM, 8'($urandom_range(1, 255)));
          cfg_write(REG_IO_QUANTUM, 8'($urandom_range(1, 255)));
        end
        default: begin
          cfg_write(REG_CPU_QUANTUM, 8'd255);
          cfg_write(REG_IO_QUANTUM, 8'd255);
        end
      endcase
      for (int i = 0; i < 250; i++) begin
        int gap;
        gap = (i % 100 < 20) ? 0 : $urandom_range(0, 4);
        if (n_loaded < Slots - 1 && $urandom_range(0, 19) == 0) send_rand(gap, OP_LOAD);
        else send_rand(gap, OP_TICK);
      end
    end

    // fill the table with a late arrival, hit table full, then keep ticking
    while (n_loaded < Slots - 1) send_rand(0, OP_LOAD);
    send_item(0, OP_LOAD, 8'hC3, 3'd2, 16'hFFFF, 12'd3, 12'd2, 1'b0, none);
    send_item(1, OP_LOAD, 8'h3C, 3'd5, 16'h0000, 12'hFFF, 12'hFFF, 1'b1,
              '{KIND_FULL, 8'd0, 16'd0});
    for (int i = 0; i < 40; i++) send_rand($urandom_range(0, 4), OP_TICK);

    drain();
    if (errs == 0 && expected_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
